// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPV_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SPV_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ----- hdl/spv_pkg.sv -----
`default_nettype none
package spv_pkg;
    localparam int WORD_W        = 32;
    localparam int MOD_WIDTH_DEF = 32;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GENERATOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PUBLIC    = 2'd2;

    localparam logic [WORD_W-1:0] MOD_RESET = 32'd23;
    localparam logic [WORD_W-1:0] GEN_RESET = 32'd5;
    localparam logic [WORD_W-1:0] PUB_RESET = 32'd17;
endpackage
`default_nettype wire

// ----- hdl/schnorr_proof_verifier_core.sv -----
`default_nettype none
// Schnorr proof verifier. Each transfer on s_axis carries a commitment r and a
// response s; one result bit (g^s == r * h^c mod p, with c = g*r mod p) comes
// back on m_axis. All arithmetic runs through a single modular multiplier, and
// each product is one multiply, 64 reduction steps and a handoff. An item needs
// 68 + popcount(s) + popcount(c) products; s_axis_tready is low while an item
// is in work. With modulus zero the block skips the products and goes to S_OUT,
// which offers a result of 0. Configuration is taken only while the block is
// idle, and a pending write holds off the input side.
module schnorr_proof_verifier_core #(
    parameter int MOD_WIDTH = spv_pkg::MOD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [63:0]                   s_axis_tdata,  // commitment[31:0], response[63:32]
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [7:0]                         m_axis_tdata,  // valid_res[0], zero fill
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [spv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [spv_pkg::WORD_W-1:0]    i_cfg_data
);
    localparam int W     = spv_pkg::WORD_W;
    localparam int BIT_W = $clog2(W);

    typedef enum logic [2:0] {
        S_IDLE, S_CHAL, S_BASE, S_MUL, S_SQ, S_FINAL, S_OUT
    } t_state;

    t_state               r_state;
    logic [MOD_WIDTH-1:0] r_mod;
    logic [W-1:0]         r_gen;
    logic [W-1:0]         r_pub;
    logic [W-1:0]         r_r;
    logic [W-1:0]         r_exp;
    logic [MOD_WIDTH-1:0] r_chal;
    logic [MOD_WIDTH-1:0] r_acc;
    logic [MOD_WIDTH-1:0] r_base;
    logic [MOD_WIDTH-1:0] r_lhs;
    logic [BIT_W-1:0]     r_bit;
    logic                 r_phase;
    logic                 r_issued;
    logic                 r_res;
    logic                 r_out_valid;

    logic                 w_start;
    logic [W-1:0]         w_a;
    logic [W-1:0]         w_b;
    logic                 w_done;
    logic [MOD_WIDTH-1:0] w_res;
    logic                 w_in_xfer;

    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_res};

    assign w_start = !r_issued && (r_state == S_CHAL || r_state == S_BASE
                     || r_state == S_SQ || r_state == S_FINAL
                     || (r_state == S_MUL && r_exp[0]));

    always_comb begin
        w_a = r_gen;
        w_b = r_r;
        unique case (r_state)
            S_CHAL: begin
                w_a = r_gen;
                w_b = r_r;
            end
            S_BASE: begin
                w_a = r_phase ? r_pub : r_gen;
                w_b = W'(1);
            end
            S_MUL: begin
                w_a = W'(r_acc);
                w_b = W'(r_base);
            end
            S_SQ: begin
                w_a = W'(r_base);
                w_b = W'(r_base);
            end
            S_FINAL: begin
                w_a = r_r;
                w_b = W'(r_acc);
            end
            default: begin
                w_a = r_gen;
                w_b = r_r;
            end
        endcase
    end

    spv_mulmod #(.MOD_WIDTH(MOD_WIDTH)) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_p     (r_mod),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mod       <= MOD_WIDTH'(spv_pkg::MOD_RESET);
            r_gen       <= spv_pkg::GEN_RESET;
            r_pub       <= spv_pkg::PUB_RESET;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
            r_bit       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    spv_pkg::REG_MODULUS:   r_mod <= i_cfg_data[MOD_WIDTH-1:0];
                    spv_pkg::REG_GENERATOR: r_gen <= i_cfg_data;
                    spv_pkg::REG_PUBLIC:    r_pub <= i_cfg_data;
                    default: ;
                endcase
            end
            // S_OUT reloads the output register itself
            if (m_axis_tvalid && m_axis_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            if (w_start) begin
                r_issued <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_r     <= s_axis_tdata[W-1:0];
                        r_exp   <= s_axis_tdata[2*W-1:W];
                        r_phase <= 1'b0;
                        r_bit   <= '0;
                        if (r_mod == '0) begin
                            r_lhs <= MOD_WIDTH'(1);
                            r_acc <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_CHAL;
                        end
                    end
                end
                S_CHAL: begin
                    if (w_done) begin
                        r_chal   <= w_res;
                        r_issued <= 1'b0;
                        r_state  <= S_BASE;
                    end
                end
                S_BASE: begin
                    if (w_done) begin
                        r_base   <= w_res;
                        r_acc    <= MOD_WIDTH'(1);
                        r_bit    <= '0;
                        r_issued <= 1'b0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (!r_exp[0]) begin
                        r_state <= S_SQ;
                    end else if (w_done) begin
                        r_acc    <= w_res;
                        r_issued <= 1'b0;
                        r_state  <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (w_done) begin
                        r_base   <= w_res;
                        r_issued <= 1'b0;
                        r_bit    <= r_bit + 1'b1;
                        if (r_bit == BIT_W'(W - 1)) begin
                            if (!r_phase) begin
                                r_lhs   <= r_acc;
                                r_phase <= 1'b1;
                                r_exp   <= W'(r_chal);
                                r_state <= S_BASE;
                            end else begin
                                r_state <= S_FINAL;
                            end
                        end else begin
                            r_exp   <= {1'b0, r_exp[W-1:1]};
                            r_state <= S_MUL;
                        end
                    end
                end
                S_FINAL: begin
                    if (w_done) begin
                        r_acc    <= w_res;
                        r_issued <= 1'b0;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    // wait for the output register to drain
                    if (!r_out_valid || m_axis_tready) begin
                        r_res       <= (r_mod != '0) && (r_lhs == r_acc);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "assert_macros.svh"

    `SPV_ASSERT_NOW(a_start_busy, i_clk, i_rst_n, w_start, r_state != S_IDLE && r_state != S_OUT)
    `SPV_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, w_in_xfer, !s_axis_tready)
    `SPV_ASSERT_NOW(a_done_issued, i_clk, i_rst_n, w_done, r_issued)

endmodule
`default_nettype wire

// ----- hdl/spv_mulmod.sv -----
`default_nettype none
// (a * b) mod p: one 32x32 multiply, then 64 shift-subtract reduction steps.
module spv_mulmod #(
    parameter int MOD_WIDTH = spv_pkg::MOD_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [spv_pkg::WORD_W-1:0] i_a,
    input  wire logic [spv_pkg::WORD_W-1:0] i_b,
    input  wire logic [MOD_WIDTH-1:0]       i_p,
    output logic                            o_done,
    output logic [MOD_WIDTH-1:0]            o_res
);
    localparam int PROD_W = 2 * spv_pkg::WORD_W;
    localparam int CNT_W  = $clog2(PROD_W);

    logic [PROD_W-1:0]  r_prod;
    logic [MOD_WIDTH-1:0] r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [MOD_WIDTH:0] w_shift;
    logic [MOD_WIDTH:0] w_diff;
    logic [MOD_WIDTH-1:0] n_rem;

    // remainder stays below p, so one compare and subtract per bit
    always_comb begin
        w_shift = {r_rem, r_prod[PROD_W-1]};
        w_diff  = w_shift - {1'b0, i_p};
        if (w_shift >= {1'b0, i_p}) begin
            n_rem = w_diff[MOD_WIDTH-1:0];
        end else begin
            n_rem = w_shift[MOD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_prod <= {r_prod[PROD_W-2:0], 1'b0};
                r_rem  <= n_rem;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_rem;
endmodule
`default_nettype wire

// ----- verif/schnorr_proof_verifier_core_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module schnorr_proof_verifier_core_tb;

    localparam logic [spv_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 30000;

    typedef struct {
        bit [31:0] commitment;
        bit [31:0] response;
    } t_proof;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [spv_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [spv_pkg::WORD_W-1:0]    i_cfg_data;

    schnorr_proof_verifier_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow of the configuration registers
    bit [31:0] mod_p;
    bit [31:0] gen_g;
    bit [31:0] pub_h;

    t_proof   proof_q[$];
    bit       verdict_q[$];
    int       n_errors;
    int       n_sent;
    int       n_checked;
    int       n_pass_verdicts;
    bit       in_sent;
    bit       out_taken;
    int       in_gap;
    int       out_gap;
    bit       hold_off;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit [63:0] pow_mod(bit [63:0] base, bit [31:0] expo, bit [63:0] m);
        bit [63:0] acc;
        bit [63:0] b;
        acc = 64'd1;
        b = base % m;
        for (int i = 0; i < 32; i++) begin
            if (expo[i]) acc = (acc * b) % m;
            b = (b * b) % m;
        end
        return acc;
    endfunction

    function automatic bit proof_holds(t_proof pr);
        bit [63:0] p;
        bit [63:0] chal;
        bit [63:0] lhs;
        bit [63:0] rhs;
        p = 64'(mod_p);
        if (p == 0) return 1'b0;
        chal = (64'(gen_g) * 64'(pr.commitment)) % p;
        lhs = pow_mod(64'(gen_g), pr.response, p);
        rhs = (64'(pr.commitment) * pow_mod(64'(pub_h), chal[31:0], p)) % p;
        return lhs == rhs;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75) return 0;
        if (roll < 95) return $urandom_range(3, 1);
        return $urandom_range(200, 20);
    endfunction

    task automatic report(string what, bit got, bit want);
        n_errors++;
        $display("MISMATCH %0s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_sent) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (proof_q.size() > 0) begin
                t_proof pr;
                pr = proof_q.pop_front();
                s_axis_tdata <= {pr.response, pr.commitment};
                s_axis_tvalid <= 1'b1;
                in_gap <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        in_sent <= s_axis_tvalid && s_axis_tready && i_rst_n;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            t_proof pr;
            pr.commitment = s_axis_tdata[31:0];
            pr.response = s_axis_tdata[63:32];
            verdict_q.insert(verdict_q.size(), proof_holds(pr));
            n_sent++;
        end
    end

    // result side
    always @(negedge i_clk) begin
        int gap;
        gap = 0;
        if (!i_rst_n || hold_off) begin
            m_axis_tready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (out_taken) gap = pick_gap();
            if (gap > 0) begin
                out_gap <= gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        out_taken <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                report("unexpected result", m_axis_tdata[0], 1'b0);
            end else begin
                bit want;
                want = verdict_q.pop_front();
                if (m_axis_tdata[0] !== want) report("valid_res", m_axis_tdata[0], want);
                if (m_axis_tdata[7:1] !== 7'd0) report("zero fill", 1'b1, 1'b0);
                n_pass_verdicts += want;
            end
            n_checked++;
        end
    end

    task automatic write_reg(logic [spv_pkg::CFG_IDX_W-1:0] idx, bit [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            spv_pkg::REG_MODULUS:   mod_p = val;
            spv_pkg::REG_GENERATOR: gen_g = val;
            spv_pkg::REG_PUBLIC:    pub_h = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (proof_q.size() != 0 || verdict_q.size() != 0 || s_axis_tvalid)
            @(negedge i_clk);
        repeat (5) @(negedge i_clk);
    endtask

    task automatic add_proof(bit [31:0] r, bit [31:0] s);
        t_proof pr;
        pr.commitment = r;
        pr.response = s;
        proof_q.insert(proof_q.size(), pr);
    endtask

    // honest prover: r = g^k, s = k + x*c mod (p-1), valid for prime p and g != 0
    task automatic add_honest(bit [31:0] x);
        bit [63:0] p;
        bit [63:0] n;
        bit [63:0] k;
        bit [63:0] r;
        bit [63:0] c;
        bit [63:0] s;
        p = 64'(mod_p);
        n = p - 1;
        k = 64'($urandom) % n;
        r = pow_mod(64'(gen_g), k[31:0], p);
        c = (64'(gen_g) * r) % p;
        s = (k + ((64'(x) % n) * c) % n) % n;
        add_proof(r[31:0], s[31:0]);
    endtask

    task automatic run_phase(bit [31:0] p, bit [31:0] g, int count);
        bit [31:0] x;
        int roll;
        x = $urandom;
        write_reg(spv_pkg::REG_MODULUS, p);
        write_reg(spv_pkg::REG_GENERATOR, g);
        if (p >= 2) write_reg(spv_pkg::REG_PUBLIC, 32'(pow_mod(64'(g), x, 64'(p))));
        else write_reg(spv_pkg::REG_PUBLIC, $urandom);
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (p >= 3 && roll < 65) begin
                add_honest(x);
                // occasionally corrupt the response
                if (roll < 10) proof_q[$].response = proof_q[$].response ^ (32'd1 << $urandom_range(31));
            end else if (roll < 85 && p != 0) begin
                add_proof($urandom % p, $urandom);
            end else begin
                add_proof($urandom, $urandom);
            end
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = spv_pkg::REG_MODULUS;
        i_cfg_data = '0;
        n_errors = 0; n_sent = 0; n_checked = 0; n_pass_verdicts = 0;
        in_sent = 1'b0; out_taken = 1'b0; in_gap = 0; out_gap = 0; hold_off = 1'b0;
        mod_p = spv_pkg::MOD_RESET; gen_g = spv_pkg::GEN_RESET; pub_h = spv_pkg::PUB_RESET;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values: p=23, g=5, h=17 (h = 5^x for x = 7 mod 22)
        add_proof(32'd0, 32'd0);
        add_proof(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_proof(32'd0, 32'hFFFF_FFFF);
        add_proof(32'hFFFF_FFFF, 32'd0);
        add_proof(32'd1, 32'd0);
        add_proof(32'd22, 32'd1);
        add_proof(32'd23, 32'd7);
        add_proof(32'd45, 32'd7);
        for (int i = 0; i < 4; i++) add_honest(32'd13);
        wait_idle();
        // ignored index must leave the registers alone
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        add_honest(32'd13);
        add_proof(32'd3, 32'd9);
        wait_idle();
        // modulus one and zero
        write_reg(spv_pkg::REG_MODULUS, 32'd1);
        add_proof(32'd5, 32'd0);
        add_proof(32'd5, 32'd1);
        add_proof(32'hFFFF_FFFF, 32'h8000_0000);
        wait_idle();
        write_reg(spv_pkg::REG_MODULUS, 32'd0);
        add_proof(32'd0, 32'd0);
        add_proof(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();

        run_phase(32'd23, 32'd5, 180);
        run_phase(32'd4294967291, 32'd2 + $urandom_range(1000), 180);
        run_phase(32'd65521, 32'd65521 + 32'd17, 180);
        run_phase(32'd2, 32'd1, 120);
        run_phase(32'd1, $urandom, 100);
        run_phase(32'd0, $urandom, 150);
        run_phase(32'hFFFF_FFFF, $urandom, 170);
        run_phase(32'd2147483647, 32'd0, 100);
        run_phase(32'd2147483647, 32'hFFFF_FFFF, 180);
        run_phase(32'd4294967291, $urandom, 170);

        repeat (20) @(posedge i_clk);
        $display("Covered %0d proofs over several modulus/generator settings, %0d accepted",
                 n_sent, n_pass_verdicts);
        $display("Results checked: %0d, mismatches: %0d", n_checked, n_errors);
        if (n_errors == 0 && verdict_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // long back-pressure stretch while the sender keeps offering
    initial begin
        wait (n_sent == 40);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #800_000_000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ----- schnorr_proof_verifier_core.f -----
+incdir+hdl
hdl/spv_pkg.sv
hdl/spv_mulmod.sv
hdl/schnorr_proof_verifier_core.sv
verif/schnorr_proof_verifier_core_tb.sv
